// ===== src/bfla_pkg.sv =====
// bfla_pkg: shared widths, codes, reset values and pool command/response
// structs for the bump and free list allocator. No dependencies.
package bfla_pkg;

  // Number and result field widths
  localparam int NUM_W    = 12;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 3;

  // Configuration register widths
  localparam int BLK_TOT_W   = 13;
  localparam int BLK_FIRST_W = 12;
  localparam int INO_TOT_W   = 11;
  localparam int INO_FIRST_W = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  // Default pool sizes
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int MAX_INODES_DEF = 1024;

  // Register reset values
  localparam logic [BLK_TOT_W-1:0]   TOTAL_BLOCKS_RST     = 13'd4096;
  localparam logic [BLK_FIRST_W-1:0] FIRST_FREE_BLOCK_RST = 12'd2;
  localparam logic [INO_TOT_W-1:0]   TOTAL_INODES_RST     = 11'd1024;
  localparam logic [INO_FIRST_W-1:0] FIRST_FREE_INODE_RST = 10'd1;

  // Bump pointer reset values (equal to the first-free reset values)
  localparam logic [BLK_TOT_W-1:0] BLK_BUMP_RST = 13'd2;
  localparam logic [INO_TOT_W-1:0] INO_BUMP_RST = 11'd1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_FORMAT      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC_BLOCK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FREE_BLOCK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALLOC_INODE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FREE_INODE  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE_BLOCK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_INODES     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE_INODE = 2'd3;

  typedef struct packed {
    logic             fmt;
    logic             alloc;
    logic             free;
    logic [NUM_W-1:0] number;
  } pool_cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0]    granted;
    logic [STATUS_W-1:0] status;
  } pool_rsp_t;

endpackage

// ===== src/bump_and_free_list_allocator.sv =====
// bump_and_free_list_allocator: top level - configuration registers, input
// register, kind decode, two bfla_pool instances and the result register.
// Depends on bfla_pkg and bfla_pool.
//
// Usage
//   Input channel: present in_kind / in_number with start; a beat is taken
//   at each rising edge with start high and busy low. busy is only high
//   in the cycle after reset, so one item can be taken every cycle.
//   Result channel: out_valid marks one beat of out_granted / out_status.
//   It is high for exactly one cycle; the receiver cannot stall it.
//   Every item gives exactly one result, in order.
//   An item is held in the input register, answered by its pool and put
//   in the result register. Throughput: one item per cycle while busy is
//   low. A chain pop uses the head's link, read in the previous cycle
//   from the link memory's registered read port; back to back pops never wait.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data,
//   always ready; write only while no item is in flight. First-free
//   values take effect at the next format item.
//   Reset: registers go to their defaults, bump pointers to the default
//   first-free values and both chains empty. Link memories are not
//   cleared; a link is only read after a free has written it.
module bump_and_free_list_allocator #(
  parameter int MAX_BLOCKS = bfla_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_INODES = bfla_pkg::MAX_INODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                start,
  output logic                                busy,
  input  logic [bfla_pkg::KIND_W-1:0]         in_kind,
  input  logic [bfla_pkg::NUM_W-1:0]          in_number,
  // result output
  output logic                                out_valid,
  output logic [bfla_pkg::NUM_W-1:0]          out_granted,
  output logic [bfla_pkg::STATUS_W-1:0]       out_status,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfla_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic [bfla_pkg::BLK_TOT_W-1:0]   total_blocks_r;
  logic [bfla_pkg::BLK_FIRST_W-1:0] first_free_block_r;
  logic [bfla_pkg::INO_TOT_W-1:0]   total_inodes_r;
  logic [bfla_pkg::INO_FIRST_W-1:0] first_free_inode_r;

  // Input stage
  logic                        busy_r;
  logic                        in_vld_r;
  logic [bfla_pkg::KIND_W-1:0] kind_r;
  logic [bfla_pkg::NUM_W-1:0]  number_r;

  // Result stage
  logic                          out_valid_r;
  logic [bfla_pkg::NUM_W-1:0]    granted_r;
  logic [bfla_pkg::STATUS_W-1:0] status_r;

  bfla_pkg::pool_cmd_t blk_cmd, ino_cmd;
  bfla_pkg::pool_rsp_t blk_rsp, ino_rsp, rsp_sel;
  logic                accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r     <= bfla_pkg::TOTAL_BLOCKS_RST;
      first_free_block_r <= bfla_pkg::FIRST_FREE_BLOCK_RST;
      total_inodes_r     <= bfla_pkg::TOTAL_INODES_RST;
      first_free_inode_r <= bfla_pkg::FIRST_FREE_INODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bfla_pkg::CFG_TOTAL_BLOCKS: begin
          total_blocks_r <= cfg_data[bfla_pkg::BLK_TOT_W-1:0];
        end
        bfla_pkg::CFG_FIRST_FREE_BLOCK: begin
          first_free_block_r <= cfg_data[bfla_pkg::BLK_FIRST_W-1:0];
        end
        bfla_pkg::CFG_TOTAL_INODES: begin
          total_inodes_r <= cfg_data[bfla_pkg::INO_TOT_W-1:0];
        end
        bfla_pkg::CFG_FIRST_FREE_INODE: begin
          first_free_inode_r <= cfg_data[bfla_pkg::INO_FIRST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register: beat capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      in_vld_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      number_r <= in_number;
    end
  end

  // Kind decode; a format item goes to both pools
  always_comb begin
    blk_cmd        = '0;
    ino_cmd        = '0;
    blk_cmd.number = number_r;
    ino_cmd.number = number_r;
    if (in_vld_r) begin
      case (kind_r)
        bfla_pkg::KIND_FORMAT: begin
          blk_cmd.fmt = 1'b1;
          ino_cmd.fmt = 1'b1;
        end
        bfla_pkg::KIND_ALLOC_BLOCK: blk_cmd.alloc = 1'b1;
        bfla_pkg::KIND_FREE_BLOCK:  blk_cmd.free  = 1'b1;
        bfla_pkg::KIND_ALLOC_INODE: ino_cmd.alloc = 1'b1;
        bfla_pkg::KIND_FREE_INODE:  ino_cmd.free  = 1'b1;
        default: begin
        end
      endcase
    end
  end

  bfla_pool #(
    .MAX_NUM  (MAX_BLOCKS),
    .TOT_W    (bfla_pkg::BLK_TOT_W),
    .FIRST_W  (bfla_pkg::BLK_FIRST_W),
    .BUMP_RST (bfla_pkg::BLK_BUMP_RST)
  ) u_blk_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (blk_cmd),
    .total      (total_blocks_r),
    .first_free (first_free_block_r),
    .rsp        (blk_rsp)
  );

  bfla_pool #(
    .MAX_NUM  (MAX_INODES),
    .TOT_W    (bfla_pkg::INO_TOT_W),
    .FIRST_W  (bfla_pkg::INO_FIRST_W),
    .BUMP_RST (bfla_pkg::INO_BUMP_RST)
  ) u_ino_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ino_cmd),
    .total      (total_inodes_r),
    .first_free (first_free_inode_r),
    .rsp        (ino_rsp)
  );

  // Format and unused kinds: granted 0, status ok (both pools answer so)
  always_comb begin
    case (kind_r)
      bfla_pkg::KIND_ALLOC_BLOCK,
      bfla_pkg::KIND_FREE_BLOCK:  rsp_sel = blk_rsp;
      bfla_pkg::KIND_ALLOC_INODE,
      bfla_pkg::KIND_FREE_INODE:  rsp_sel = ino_rsp;
      default:                    rsp_sel = '0;
    endcase
  end

  // Result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      granted_r <= rsp_sel.granted;
      status_r  <= rsp_sel.status;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_granted = granted_r;
  assign out_status  = status_r;

  // Every captured item produces its result beat on the next edge
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid_r)
    else $error("captured item gave no result");

  // A failed request never carries a number
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != bfla_pkg::ST_OK)) |-> (granted_r == '0))
    else $error("number granted with error status");

  // Reset leaves no result strobe behind
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result strobe after reset");

endmodule

// ===== src/bfla_pool.sv =====
// bfla_pool: one number pool - bump pointer, LIFO free chain head and the
// per-number link memory with a prefetched read of the head's link.
// Depends on bfla_pkg.
module bfla_pool #(
  parameter int MAX_NUM = bfla_pkg::MAX_BLOCKS_DEF,
  parameter int TOT_W   = bfla_pkg::BLK_TOT_W,
  parameter int FIRST_W = bfla_pkg::BLK_FIRST_W,
  parameter logic [TOT_W-1:0] BUMP_RST = bfla_pkg::BLK_BUMP_RST
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bfla_pkg::pool_cmd_t   cmd,
  input  logic [TOT_W-1:0]      total,
  input  logic [FIRST_W-1:0]    first_free,
  output bfla_pkg::pool_rsp_t   rsp
);

  localparam int NUM_W = bfla_pkg::NUM_W;
  // Numbers that can ever be valid: below MAX_NUM, the input range and the total range
  localparam int D0    = (MAX_NUM < (1 << NUM_W)) ? MAX_NUM : (1 << NUM_W);
  localparam int DEPTH = (D0 < (1 << TOT_W)) ? D0 : (1 << TOT_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = ((TOT_W > NUM_W) ? TOT_W : NUM_W) + 1;
  localparam bit MAX_BIG = (MAX_NUM >= (1 << TOT_W));
  localparam logic [TOT_W-1:0] MAX_T = MAX_BIG ? '1 : TOT_W'(MAX_NUM);

  logic [TOT_W-1:0] bump_r, bump_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    link_q_r;          // links[head_r], prefetched
  logic [AW-1:0]    links [DEPTH];
  logic [TOT_W-1:0] limit;
  logic             free_bad;
  logic             we;
  logic [AW-1:0]    num_a;

  assign limit = (MAX_BIG || (total < MAX_T)) ? total : MAX_T;
  assign num_a = cmd.number[AW-1:0];
  assign free_bad = (cmd.number == '0)
                 || (CW'(cmd.number) >= CW'(limit))
                 || (CW'(cmd.number) >= CW'(DEPTH));

  always_comb begin
    bump_nxt    = bump_r;
    head_nxt    = head_r;
    we          = 1'b0;
    rsp.granted = '0;
    rsp.status  = bfla_pkg::ST_OK;
    if (cmd.fmt) begin
      bump_nxt = (first_free == '0) ? TOT_W'(1) : TOT_W'(first_free);
      head_nxt = '0;
    end else if (cmd.alloc) begin
      if (bump_r < limit) begin
        rsp.granted = NUM_W'(bump_r);
        bump_nxt    = bump_r + 1'b1;
      end else if (head_r != '0) begin
        rsp.granted = NUM_W'(head_r);
        head_nxt    = link_q_r;
      end else begin
        rsp.status = bfla_pkg::ST_EXHAUSTED;
      end
    end else if (cmd.free) begin
      if (free_bad) begin
        rsp.status = bfla_pkg::ST_INVALID;
      end else begin
        we       = 1'b1;
        head_nxt = num_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r <= BUMP_RST;
      head_r <= '0;
    end else begin
      bump_r <= bump_nxt;
      head_r <= head_nxt;
    end
  end

  // Link memory: one write, one registered read at the next head.
  // A push writes the new head's link, so forward the written value.
  always_ff @(posedge clk) begin
    if (we) begin
      links[num_a] <= head_r;
    end
    link_q_r <= we ? head_r : links[head_nxt];
  end

  // Bump pointer never reaches zero, so number 0 is never handed out
  a_bump_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r != '0)
    else $error("bump pointer is zero");

  // Chain head always names a storable number
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < DEPTH)
    else $error("chain head out of range");

  // A good free makes the freed number the new head
  a_push_head: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.fmt && !cmd.alloc && cmd.free && !free_bad) |=> head_r == $past(num_a))
    else $error("free did not push onto chain");

endmodule
